FILE: design/tsnc_pkg.sv
// Package for the slotted radio-node scheduler: payload structs, codes, constants.
// Used by tdma_slot_sync_neighbor_counter_unit; depends on nothing.
package tsnc_pkg;

  // Size of the neighbor list and the widths that follow from it.
  localparam int MAX_NEIGHBORS = 8;
  localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

  // Input command codes.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_CALL = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_ADDRESS      = 2'd0;
  localparam logic [1:0] REG_SLOT_LENGTH      = 2'd1;
  localparam logic [1:0] REG_SUBCYCLE_LENGTH  = 2'd2;
  localparam logic [1:0] REG_CYCLES_PER_ROUND = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_OWN_ADDRESS      = 8'd0;
  localparam logic [15:0] RST_SLOT_LENGTH      = 16'd100;
  localparam logic [15:0] RST_SUBCYCLE_LENGTH  = 16'd1000;
  localparam logic [7:0]  RST_CYCLES_PER_ROUND = 8'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  sender_address;
    logic [7:0]  sender_cycle;
    logic [15:0] sender_time;
  } in_item_t;

  typedef struct packed {
    logic        send_packet;
    logic [7:0]  packet_cycle;
    logic [15:0] packet_time;
    logic        round_end;
    logic [3:0]  neighbor_count;
    logic        radio_listen;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SEARCH,
    ST_APPEND
  } state_t;

endpackage

FILE: design/tsnc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the neighbor list of the scheduler.
module tsnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tdma_slot_sync_neighbor_counter_unit.sv
// Top level of the slotted radio-node scheduler with neighbor counting.
// Depends on tsnc_pkg and tsnc_ram.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries timer ticks and
//   received call packets. A tick advances the subcycle timer and may give
//   one result on the output channel (out_valid/out_ready/out_data): a
//   request to send a call packet, a subcycle end, or both. Calls give no
//   result; they adjust timing and note the sender in the neighbor list.
//   The configuration port (cfg_write/cfg_index/cfg_data) writes a register.
//   Users must use it only while the block is idle; nothing enforces it.
// Operation:
//   A tick passes through the ST_TICK state into the output register.
//   A call searches the neighbor list, which sits in a one-read-port RAM,
//   one entry per cycle; a new sender is then appended in the ST_APPEND
//   state. Other commands are dropped; new items are taken only in ST_IDLE.
// Reset:
//   rst restores the configuration defaults, clears the timer, cycle number
//   and neighbor count, and empties the output register. No clearing pass.
// Stall:
//   A result waits in the output register while new items are still taken;
//   a tick that produces a further result holds until that register frees.
module tdma_slot_sync_neighbor_counter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsnc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsnc_pkg::out_item_t out_data
);
  import tsnc_pkg::*;

  // Configuration registers.
  logic [7:0]  own_address;
  logic [15:0] slot_length;
  logic [15:0] subcycle_length;
  logic [7:0]  cycles_per_round;

  // Block state.
  state_t     state, state_next;
  logic [15:0] subcycle_timer, subcycle_timer_next;
  logic [7:0]  cycle_number, cycle_number_next;
  logic [CNT_W-1:0] neighbors_seen, neighbors_seen_next;
  logic [IDX_W-1:0] search_idx, search_idx_next;
  in_item_t    item;
  out_item_t   result_next;
  logic        load_result;

  // Neighbor list RAM signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Tick arithmetic.
  logic [16:0]      timer_inc;
  logic             sub_end;
  logic             round_wrap;
  logic [15:0]      tick_timer;
  logic [7:0]       tick_cycle;
  logic             tick_listen;
  logic [23:0]      slot_start;
  logic             send;
  logic [CNT_W-1:0] idx_inc;
  logic             accept;

  tsnc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_NEIGHBORS)
  ) u_list (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.sender_address),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address      <= RST_OWN_ADDRESS;
      slot_length      <= RST_SLOT_LENGTH;
      subcycle_length  <= RST_SUBCYCLE_LENGTH;
      cycles_per_round <= RST_CYCLES_PER_ROUND;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:      own_address      <= cfg_data[7:0];
        REG_SLOT_LENGTH:      slot_length      <= cfg_data;
        REG_SUBCYCLE_LENGTH:  subcycle_length  <= cfg_data;
        REG_CYCLES_PER_ROUND: cycles_per_round <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Tick evaluation: timer wrap first, then the slot start check.
  always_comb begin
    timer_inc   = {1'b0, subcycle_timer} + 17'd1;
    sub_end     = (timer_inc >= {1'b0, subcycle_length});
    round_wrap  = ({1'b0, cycle_number} + 9'd1) >= {1'b0, cycles_per_round};
    tick_timer  = sub_end ? 16'd0 : timer_inc[15:0];
    tick_cycle  = cycle_number;
    tick_listen = 1'b0;
    if (sub_end) begin
      tick_cycle  = round_wrap ? 8'd0 : cycle_number + 8'd1;
      tick_listen = round_wrap;
    end
    slot_start = {16'd0, own_address} * {8'd0, slot_length};
    send       = ({8'd0, tick_timer} == slot_start);
    if (send) begin
      tick_listen = (tick_cycle == 8'd0);
    end
    result_next.send_packet    = send;
    result_next.packet_cycle   = send ? tick_cycle : 8'd0;
    result_next.packet_time    = send ? tick_timer : 16'd0;
    result_next.round_end      = sub_end && round_wrap;
    result_next.neighbor_count = (sub_end && round_wrap) ?
                                 4'(neighbors_seen) : 4'd0;
    result_next.radio_listen   = tick_listen;
  end

  assign idx_inc = CNT_W'(search_idx) + CNT_W'(1);

  // Sequencer: next state, state updates and RAM control.
  always_comb begin
    state_next          = state;
    subcycle_timer_next = subcycle_timer;
    cycle_number_next   = cycle_number;
    neighbors_seen_next = neighbors_seen;
    search_idx_next     = search_idx;
    load_result         = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = neighbors_seen[IDX_W-1:0];
    ram_raddr           = '0;
    unique case (state)
      ST_IDLE: begin
        search_idx_next = '0;
        if (accept) begin
          if (in_data.command == CMD_TICK) begin
            state_next = ST_TICK;
          end else if (in_data.command == CMD_CALL) begin
            // A call from a lower address takes over its timing.
            if (in_data.sender_address < own_address) begin
              cycle_number_next   = in_data.sender_cycle;
              subcycle_timer_next = in_data.sender_time;
            end
            state_next = (neighbors_seen == '0) ? ST_APPEND : ST_SEARCH;
          end
        end
      end
      ST_TICK: begin
        if (!(send || sub_end)) begin
          subcycle_timer_next = tick_timer;
          cycle_number_next   = tick_cycle;
          state_next          = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          subcycle_timer_next = tick_timer;
          cycle_number_next   = tick_cycle;
          if (sub_end && round_wrap) begin
            neighbors_seen_next = '0;
          end
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        // ram_rdata holds entry search_idx.
        if (ram_rdata == item.sender_address) begin
          state_next = ST_IDLE;
        end else if (idx_inc >= neighbors_seen) begin
          state_next = ST_APPEND;
        end else begin
          ram_raddr       = idx_inc[IDX_W-1:0];
          search_idx_next = idx_inc[IDX_W-1:0];
        end
      end
      ST_APPEND: begin
        // A full list keeps its contents and count.
        if (neighbors_seen < CNT_W'(MAX_NEIGHBORS)) begin
          ram_we              = 1'b1;
          neighbors_seen_next = neighbors_seen + CNT_W'(1);
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      subcycle_timer <= 16'd0;
      cycle_number   <= 8'd0;
      neighbors_seen <= '0;
      search_idx     <= '0;
    end else begin
      state          <= state_next;
      subcycle_timer <= subcycle_timer_next;
      cycle_number   <= cycle_number_next;
      neighbors_seen <= neighbors_seen_next;
      search_idx     <= search_idx_next;
    end
  end

  // Accepted item is held for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_data <= result_next;
    end
  end

endmodule
